// File: design/rad_pkg.sv
// Shared types, constants and codes for the recentering array deque.
package rad_pkg;
  localparam int MAX_CAPACITY = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int AW = $clog2(MAX_CAPACITY);
  localparam int CW = AW + 1;

  localparam logic [2:0] FUNC_PUSH_BACK = 3'd0;
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
  localparam logic [2:0] FUNC_POP_BACK = 3'd2;
  localparam logic [2:0] FUNC_POP_FRONT = 3'd3;
  localparam logic [2:0] FUNC_GET = 3'd4;
  localparam logic [2:0] FUNC_SET = 3'd5;

  localparam logic [1:0] REG_INIT_CAP = 2'd0;
  localparam logic [1:0] REG_LOW_FACTOR = 2'd1;
  localparam logic [1:0] REG_HIGH_FACTOR = 2'd2;

  typedef struct packed {
    logic start;
    logic copy_rd;
    logic copy_wr;
    logic copy_done;
    logic finish;
  } rad_cmd_t;

  typedef struct packed {
    logic need_copy;
    logic copy_last;
    logic refused;
    logic copy_empty;
  } rad_sts_t;
endpackage

// File: design/rad_ctrl.sv
// Controller state machine sequencing an operation and its re-centering copy.
module rad_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_free,
  input  rad_pkg::rad_sts_t sts,
  output rad_pkg::rad_cmd_t cmd,
  output logic              busy
);
  import rad_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_CRD = 3'd2;
  localparam logic [2:0] ST_CWR = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.start = in_fire;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.need_copy && !sts.refused) begin
          if (sts.copy_empty) begin
            cmd.copy_done = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_CRD;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_CRD: begin
        cmd.copy_rd = 1'b1;
        state_nxt = ST_CWR;
      end
      ST_CWR: begin
        cmd.copy_wr = 1'b1;
        if (sts.copy_last) begin
          cmd.copy_done = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CRD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
endmodule

// File: design/rad_dp.sv
// Datapath: element store, deque pointers, resize arithmetic and result register.
module rad_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_idx,
  input  logic [10:0]                     cfg_wdata,
  input  logic [2:0]                      op_func,
  input  logic [9:0]                      op_index,
  input  logic [rad_pkg::DATA_WIDTH-1:0]  op_value,
  input  rad_pkg::rad_cmd_t               cmd,
  output rad_pkg::rad_sts_t               sts,
  output logic                            res_ok,
  output logic [rad_pkg::DATA_WIDTH-1:0]  res_read,
  output logic [rad_pkg::CW-1:0]          res_count,
  output logic [rad_pkg::CW-1:0]          res_cap
);
  import rad_pkg::*;

  logic [DATA_WIDTH-1:0] mem [MAX_CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;

  logic [10:0] init_cap_r;
  logic [3:0]  low_r;
  logic [4:0]  high_r;
  logic signed [CW:0] head_r;
  logic [CW-1:0] count_r, cap_r;

  logic [2:0] func_r;
  logic [9:0] idx_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0] newcap_r, start_r, ci_r;
  logic need_r, refuse_r, ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cap_r <= 11'd8;
      low_r <= 4'd2;
      high_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_INIT_CAP: init_cap_r <= cfg_wdata;
        REG_LOW_FACTOR: low_r <= cfg_wdata[3:0];
        REG_HIGH_FACTOR: high_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Decide in the start cycle what the operation needs.
  logic is_push, is_front, is_pop, has_room, room_ok;
  logic [15:0] lowprod, highprod;
  logic [15:0] pcap;
  logic [CW-1:0] cnt_after;
  logic [16:0] pstart;
  logic signed [CW+1:0] tailpos;
  logic signed [CW+1:0] fpos;
  always_comb begin
    is_push = (op_func == FUNC_PUSH_BACK) || (op_func == FUNC_PUSH_FRONT);
    is_pop = (op_func == FUNC_POP_BACK) || (op_func == FUNC_POP_FRONT);
    is_front = (op_func == FUNC_PUSH_FRONT) || (op_func == FUNC_POP_FRONT);
    cnt_after = is_pop ? count_r - CW'(1) : count_r;
    lowprod = 16'(low_r) * 16'(cnt_after);
    highprod = 16'(high_r) * 16'(cnt_after);
    tailpos = (CW+2)'(head_r) + (CW+2)'(signed'({1'b0, count_r})) + (CW+2)'(1);
    has_room = is_front ? (head_r >= 0)
                        : (tailpos < (CW+2)'(signed'({1'b0, cap_r})));
    if (is_push) begin
      pcap = ({5'd0, cap_r} < {5'd0, init_cap_r}) ? 16'(init_cap_r) : lowprod;
    end else begin
      pcap = (lowprod < 16'(init_cap_r)) ? 16'(init_cap_r) : lowprod;
    end
    pstart = (17'(pcap) - 17'(cnt_after)) >> 1;
    room_ok = (pcap <= 16'(MAX_CAPACITY)) && (pcap >= 16'(cnt_after));
    if (room_ok && is_push) begin
      room_ok = is_front ? (pstart >= 17'd1)
                         : ((pstart + 17'(count_r)) < 17'(pcap));
    end
    fpos = (CW+2)'(head_r) + (CW+2)'(1);
  end

  logic signed [CW+1:0] srcpos;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic wr_en;
  logic copy_up;
  logic [CW-1:0] coff;

  always_comb begin
    sts.need_copy = need_r;
    sts.refused = refuse_r;
    sts.copy_empty = (count_r == '0);
    sts.copy_last = (ci_r + CW'(1) >= count_r);
  end

  // A window that moves up is copied from its top element down, so that no
  // element is overwritten before it has been read.
  always_comb begin
    copy_up = (CW+2)'(signed'({1'b0, start_r})) > fpos;
    coff = copy_up ? count_r - CW'(1) - ci_r : ci_r;
    srcpos = fpos + (CW+2)'(signed'({1'b0, coff}));
    rd_addr = (srcpos < 0 || srcpos >= MAX_CAPACITY) ? '0 : srcpos[AW-1:0];
  end

  // Slot address for the final access of the operation.
  logic signed [CW+1:0] fin_pos;
  logic [AW-1:0] fin_addr;
  logic fin_we;
  always_comb begin
    fin_we = 1'b0;
    case (func_r)
      FUNC_PUSH_BACK: begin
        fin_pos = (CW+2)'(head_r) + (CW+2)'(signed'({1'b0, count_r})) + (CW+2)'(1);
        fin_we = ok_r;
      end
      FUNC_PUSH_FRONT: begin
        fin_pos = (CW+2)'(head_r);
        fin_we = ok_r;
      end
      FUNC_SET: begin
        fin_pos = fpos + (CW+2)'(idx_r);
        fin_we = ok_r;
      end
      default: fin_pos = fpos + (CW+2)'(idx_r);
    endcase
    fin_addr = (fin_pos < 0 || fin_pos >= MAX_CAPACITY) ? '0 : fin_pos[AW-1:0];
    wr_en = cmd.copy_wr || (cmd.finish && fin_we);
    wr_addr = cmd.copy_wr ? AW'(start_r + coff) : fin_addr;
    wr_data = cmd.copy_wr ? rdata_r : val_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_rd) rdata_r <= mem[rd_addr];
    else if (func_r == FUNC_GET) rdata_r <= mem[fin_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= (CW+1)'(signed'({1'b0, 11'd4})) - (CW+1)'(1);
      count_r <= '0;
      cap_r <= CW'(8);
      need_r <= 1'b0;
      refuse_r <= 1'b0;
      ok_r <= 1'b0;
      ci_r <= '0;
    end else begin
      if (cmd.start) begin
        func_r <= op_func;
        idx_r <= op_index;
        val_r <= op_value;
        ci_r <= '0;
        newcap_r <= pcap[CW-1:0];
        start_r <= pstart[CW-1:0];
        need_r <= 1'b0;
        refuse_r <= 1'b0;
        ok_r <= 1'b0;
        if (is_push) begin
          need_r <= !has_room;
          refuse_r <= !has_room && !room_ok;
          ok_r <= has_room || room_ok;
        end else if (is_pop) begin
          ok_r <= (count_r != 0);
          if (count_r != 0) begin
            count_r <= count_r - CW'(1);
            if (is_front) head_r <= head_r + (CW+1)'(1);
            if ({5'd0, cap_r} > highprod && room_ok) begin
              need_r <= 1'b1;
            end
          end
        end else if (op_func == FUNC_GET || op_func == FUNC_SET) begin
          ok_r <= ({1'b0, op_index} < count_r);
        end
      end
      if (cmd.copy_wr) ci_r <= ci_r + CW'(1);
      if (cmd.copy_done) begin
        head_r <= (CW+1)'(signed'({1'b0, start_r})) - (CW+1)'(1);
        cap_r <= newcap_r;
      end
      if (cmd.finish) begin
        if (ok_r && func_r == FUNC_PUSH_FRONT) begin
          head_r <= head_r - (CW+1)'(1);
          count_r <= count_r + CW'(1);
        end else if (ok_r && func_r == FUNC_PUSH_BACK) begin
          count_r <= count_r + CW'(1);
        end
      end
    end
  end

  assign res_ok = ok_r;
  assign res_read = (func_r == FUNC_GET && ok_r) ? rdata_r : '0;
  assign res_count = count_r + ((ok_r && (func_r == FUNC_PUSH_BACK
                    || func_r == FUNC_PUSH_FRONT)) ? CW'(1) : CW'(0));
  assign res_cap = cap_r;
endmodule

// File: design/recentering_array_deque.sv
// Top level of the recentering array deque: handshakes, controller and datapath.
//   channel  | direction | accepted when
//   in_      | slave     | in_tvalid && in_tready
//   out_     | master    | out_tvalid && out_tready
//   cfg_     | write     | cfg_we
// An ordinary operation passes from acceptance through ST_DECIDE to ST_FIN, where
// its result is written to the output register.
// A re-centering copies each element held with a read state (ST_CRD) and then a
// write state (ST_CWR).
// Reset is synchronous and active low; the store holds no reset value.
// A result waits in the output register while the next transaction is taken; that
// transaction holds in its last cycle until the register is free.
module recentering_array_deque (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func[2:0], index[12:3], value[44:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // ok[0], read_value[32:1], count[43:33], capacity_now[54:44]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [10:0] cfg_wdata
);
  import rad_pkg::*;

  rad_cmd_t cmd;
  rad_sts_t sts;
  logic busy, in_fire, ok;
  logic [DATA_WIDTH-1:0] rdv;
  logic [CW-1:0] cnt, cap;
  logic out_valid_r;
  logic [55:0] out_data_r;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  rad_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_free(!out_valid_r || out_tready), .sts(sts), .cmd(cmd), .busy(busy)
  );

  rad_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .op_func(in_tdata[2:0]), .op_index(in_tdata[12:3]),
    .op_value(in_tdata[44:13]), .cmd(cmd), .sts(sts), .res_ok(ok),
    .res_read(rdv), .res_count(cnt), .res_cap(cap)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= {1'b0, cap, cnt, rdv, ok};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.copy_rd && cmd.copy_wr)) else $error("copy read and write overlap");
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> busy) else $error("finish while idle");
  a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_tvalid) else $error("result lost");
endmodule

// File: bench/recentering_array_deque_test.sv
// Self-checking testbench for the recentering array deque: directed, random and backpressure tests.
`timescale 1ns / 1ps

module recentering_array_deque_test;
  import rad_pkg::*;

  localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [10:0] count;
    logic [10:0] capacity_now;
  } deque_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // func[2:0], index[12:3], value[44:13]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // ok[0], read_value[32:1], count[43:33], capacity_now[54:44]
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [10:0] cfg_wdata;

  recentering_array_deque dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the deque and its registers.
  logic [31:0] shadow_store [MAX_CAPACITY];
  int shadow_head;
  int shadow_count;
  int shadow_cap;
  int init_cap_reg;
  int low_factor_reg;
  int high_factor_reg;

  deque_result_t pending_results[$];
  int errors;
  int hold_left;
  int burst_left;
  bit gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #250_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int store_slot(int pos);
    return (pos < 0 || pos >= MAX_CAPACITY) ? 0 : pos;
  endfunction

  function automatic void recenter_shadow(int newcap);
    logic [31:0] copy_buf [MAX_CAPACITY];
    int start;
    for (int i = 0; i < shadow_count; i++)
      copy_buf[i] = shadow_store[store_slot(shadow_head + 1 + i)];
    start = (newcap - shadow_count) / 2;
    for (int i = 0; i < shadow_count; i++)
      shadow_store[store_slot(start + i)] = copy_buf[i];
    shadow_head = start - 1;
    shadow_cap = newcap;
  endfunction

  function automatic bit push_shadow(logic [31:0] v, bit front);
    bit has_room;
    int newcap;
    int start;
    has_room = front ? (shadow_head >= 0) : (shadow_head + shadow_count + 1 < shadow_cap);
    if (!has_room) begin
      newcap = (shadow_cap < init_cap_reg) ? init_cap_reg : low_factor_reg * shadow_count;
      if (newcap > MAX_CAPACITY || newcap < shadow_count) return 1'b0;
      start = (newcap - shadow_count) / 2;
      if (front ? (start < 1) : (start + shadow_count >= newcap)) return 1'b0;
      recenter_shadow(newcap);
    end
    if (front) begin
      shadow_store[store_slot(shadow_head)] = v;
      shadow_head--;
    end else begin
      shadow_store[store_slot(shadow_head + shadow_count + 1)] = v;
    end
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic bit pop_shadow(bit front);
    int newcap;
    if (shadow_count == 0) return 1'b0;
    if (front) shadow_head++;
    shadow_count--;
    if (shadow_cap > high_factor_reg * shadow_count) begin
      newcap = low_factor_reg * shadow_count;
      if (newcap < init_cap_reg) newcap = init_cap_reg;
      if (newcap <= MAX_CAPACITY && newcap >= shadow_count) recenter_shadow(newcap);
    end
    return 1'b1;
  endfunction

  function automatic deque_result_t predict_deque_op(logic [2:0] func, logic [9:0] idx,
                                                     logic [31:0] v);
    deque_result_t r;
    r = '0;
    case (func)
      FUNC_PUSH_BACK:  r.ok = push_shadow(v, 1'b0);
      FUNC_PUSH_FRONT: r.ok = push_shadow(v, 1'b1);
      FUNC_POP_BACK:   r.ok = pop_shadow(1'b0);
      FUNC_POP_FRONT:  r.ok = pop_shadow(1'b1);
      FUNC_GET: begin
        if (idx < shadow_count) begin
          r.read_value = shadow_store[store_slot(shadow_head + 1 + idx)];
          r.ok = 1'b1;
        end
      end
      FUNC_SET: begin
        if (idx < shadow_count) begin
          shadow_store[store_slot(shadow_head + 1 + idx)] = v;
          r.ok = 1'b1;
        end
      end
      default: r.ok = 1'b0;
    endcase
    r.count = shadow_count[10:0];
    r.capacity_now = shadow_cap[10:0];
    return r;
  endfunction

  task automatic send_op(logic [2:0] func, logic [9:0] idx, logic [31:0] v);
    int gap;
    gap = 0;
    if (gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, v, idx, func};
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), predict_deque_op(func, idx, v));
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[10:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INIT_CAP:    init_cap_reg = value & 'h7FF;
      REG_LOW_FACTOR:  low_factor_reg = value & 'hF;
      REG_HIGH_FACTOR: high_factor_reg = value & 'h1F;
      default: ;
    endcase
  endtask

  task automatic set_regs(int init_cap, int low_f, int high_f);
    drain();
    write_reg(REG_INIT_CAP, init_cap);
    write_reg(REG_LOW_FACTOR, low_f);
    write_reg(REG_HIGH_FACTOR, high_f);
  endtask

  // Random mix whose pushes and pops keep the count drifting toward fill_target.
  task automatic run_mix(int n, int fill_target);
    int r;
    int push_w;
    logic [9:0] idx;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      push_w = (shadow_count < fill_target) ? 50 : 20;
      idx = $urandom_range(0, 1023);
      if (shadow_count > 0 && $urandom_range(0, 9) < 8)
        idx = $urandom_range(0, shadow_count - 1);
      if (r < 2)
        send_op($urandom_range(0, 1) ? FUNC_UNUSED_7 : FUNC_UNUSED_6, idx, $urandom);
      else if (r < 2 + push_w)
        send_op($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, idx, $urandom);
      else if (r < 27 + push_w)
        send_op($urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK, idx, $urandom);
      else
        send_op($urandom_range(0, 1) ? FUNC_SET : FUNC_GET, idx, $urandom);
    end
  endtask

  task automatic test_directed;
    send_op(FUNC_POP_BACK, 10'd0, 32'd0);
    send_op(FUNC_POP_FRONT, 10'd0, 32'd0);
    send_op(FUNC_GET, 10'd0, 32'd0);
    send_op(FUNC_SET, 10'd0, 32'hFFFF_FFFF);
    send_op(FUNC_UNUSED_6, 10'h3FF, 32'hFFFF_FFFF);
    send_op(FUNC_UNUSED_7, 10'd0, 32'd0);
    send_op(FUNC_PUSH_BACK, 10'd0, 32'h7FFF_FFFF);
    send_op(FUNC_PUSH_FRONT, 10'h3FF, 32'h8000_0000);
    send_op(FUNC_GET, 10'd0, 32'd0);
    send_op(FUNC_GET, 10'd1, 32'd0);
    send_op(FUNC_GET, 10'h3FF, 32'd0);
    send_op(FUNC_SET, 10'd0, 32'hFFFF_FFFF);
    send_op(FUNC_SET, 10'd2, 32'h1234_5678);
    for (int i = 0; i < 6; i++) send_op(FUNC_PUSH_FRONT, 10'd0, $urandom);
    for (int i = 0; i < 6; i++) send_op(FUNC_POP_BACK, 10'd0, 32'd0);
  endtask

  task automatic test_register_sweep;
    set_regs(2, 1, 2);
    run_mix(180, 6);
    set_regs(1024, 8, 16);
    run_mix(180, 12);
    set_regs(2, 8, 2);
    run_mix(180, 20);
    set_regs(8, 1, 16);
    run_mix(180, 10);
    set_regs(3, 3, 5);
    run_mix(180, 30);
  endtask

  // Grows the deque by a factor of eight toward the size of the store.
  task automatic test_store_full;
    set_regs(16, 8, 16);
    repeat (150) send_op($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, 10'd0,
                         $urandom);
    run_mix(40, 0);
    set_regs(16, 8, 16);
    while (shadow_count > 0) send_op(FUNC_POP_FRONT, 10'd0, 32'd0);
  endtask

  task automatic test_backpressure;
    set_regs(8, 2, 4);
    hold_left = 300;
    run_mix(40, 10);
    drain();
    run_mix(20, 10);
  endtask

  task automatic test_random;
    set_regs(8, 2, 4);
    run_mix(150, 16);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (($time / 2000) % 4)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 7) != 0);
          default: out_tready <= (($time / 10) % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, out_tdata);
        errors++;
      end else begin
        deque_result_t want;
        deque_result_t got;
        want = pending_results[0];
        pending_results.delete(0);
        got.ok = out_tdata[0];
        got.read_value = out_tdata[32:1];
        got.count = out_tdata[43:33];
        got.capacity_now = out_tdata[54:44];
        if (got.ok !== want.ok) begin
          $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
          errors++;
        end
        if (got.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   got.read_value);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
          errors++;
        end
        if (got.capacity_now !== want.capacity_now) begin
          $display("%0t: capacity_now expected %0d actual %0d", $time, want.capacity_now,
                   got.capacity_now);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    hold_left = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    init_cap_reg = 8;
    low_factor_reg = 2;
    high_factor_reg = 4;
    shadow_count = 0;
    shadow_cap = 8;
    shadow_head = 3;
    for (int i = 0; i < MAX_CAPACITY; i++) shadow_store[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    gaps_on = 1'b1;
    test_register_sweep();
    test_store_full();
    test_backpressure();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
